@@ rtl/csac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csac_pkg
// shared types, codes and field helpers for the clock set and alarm controller
// ----------------------------------------------------------------------------
package csac_pkg;

  localparam int VAL_W  = 7;
  localparam int BEEP_W = 3;
  localparam int EDIT_W = 3;

  // item kinds
  typedef enum logic [2:0] {
    KIND_SET        = 3'd0,
    KIND_UP         = 3'd1,
    KIND_DOWN       = 3'd2,
    KIND_MENU       = 3'd3,
    KIND_MENU_LONG  = 3'd4,
    KIND_SAMPLE     = 3'd5
  } kind_t;

  // selectable fields
  typedef enum logic [3:0] {
    SEL_NONE         = 4'd0,
    SEL_YEAR         = 4'd1,
    SEL_MONTH        = 4'd2,
    SEL_DAY          = 4'd3,
    SEL_WEEKDAY      = 4'd4,
    SEL_HOUR         = 4'd5,
    SEL_MINUTE       = 4'd6,
    SEL_SECOND       = 4'd7,
    SEL_ALARM_HOUR   = 4'd8,
    SEL_ALARM_MINUTE = 4'd9
  } sel_t;

  // alarm menu steps
  typedef enum logic [1:0] {
    MENU_CLOSED = 2'd0,
    MENU_DISARM = 2'd1,
    MENU_HOUR   = 2'd2,
    MENU_MINUTE = 2'd3
  } menu_t;

  localparam logic [EDIT_W-1:0] EDIT_IDLE = 3'd0;
  localparam logic [EDIT_W-1:0] EDIT_LAST = 3'd7;

  localparam logic [BEEP_W-1:0] BEEP_NONE  = 3'd0;
  localparam logic [BEEP_W-1:0] BEEP_ONE   = 3'd1;
  localparam logic [BEEP_W-1:0] BEEP_CHIME = 3'd3;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } rtc_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
  } fields_t;

  typedef struct packed {
    logic load;
    logic step;
    logic up;
    sel_t sel;
  } field_cmd_t;

  typedef struct packed {
    logic [BEEP_W-1:0] beeps;
    logic              commit;
    sel_t              sel;
  } result_t;

  typedef struct packed {
    logic [EDIT_W-1:0] edit_step;
    menu_t             menu_step;
    logic              armed;
    logic              mute;
    logic              hour12;
  } status_t;

  function automatic logic [VAL_W-1:0] field_lo(input sel_t s);
    logic [VAL_W-1:0] r;
    case (s)
      SEL_MONTH, SEL_DAY, SEL_WEEKDAY: r = 7'd1;
      default:                         r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] field_hi(input sel_t s);
    logic [VAL_W-1:0] r;
    case (s)
      SEL_YEAR:                           r = 7'd99;
      SEL_MONTH:                          r = 7'd12;
      SEL_DAY:                            r = 7'd31;
      SEL_WEEKDAY:                        r = 7'd7;
      SEL_HOUR, SEL_ALARM_HOUR:           r = 7'd23;
      SEL_MINUTE, SEL_SECOND,
      SEL_ALARM_MINUTE:                   r = 7'd59;
      default:                            r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] field_read(input fields_t f, input sel_t s);
    logic [VAL_W-1:0] r;
    case (s)
      SEL_YEAR:         r = f.year;
      SEL_MONTH:        r = {3'd0, f.month};
      SEL_DAY:          r = {2'd0, f.day};
      SEL_WEEKDAY:      r = {4'd0, f.weekday};
      SEL_HOUR:         r = {2'd0, f.hour};
      SEL_MINUTE:       r = {1'd0, f.minute};
      SEL_SECOND:       r = {1'd0, f.second};
      SEL_ALARM_HOUR:   r = {2'd0, f.alarm_hour};
      SEL_ALARM_MINUTE: r = {1'd0, f.alarm_minute};
      default:          r = '0;
    endcase
    return r;
  endfunction

  // one step up or down with wraparound between lo and hi
  function automatic logic [VAL_W-1:0] step_value(input logic [VAL_W-1:0] v,
                                                  input logic [VAL_W-1:0] lo,
                                                  input logic [VAL_W-1:0] hi,
                                                  input logic up);
    logic [VAL_W-1:0] r;
    if (up) begin
      r = (v >= hi) ? lo : v + 7'd1;
    end else begin
      r = (v <= lo || v > hi) ? hi : v - 7'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/clock_set_alarm_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_set_alarm_controller
// time set, alarm menu and chime control for a digital clock
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one item: a key event or a
//   clock sample (kind plus the rtc_* reading). output channel (out_valid /
//   out_stall) carries result items, each a full view of the controller.
//   the result of an item is registered: it is on the output the cycle after accept.
//   throughput: one item per cycle while results drain; most items give one
//   result. the commit item (eighth set press) gives seven results, year
//   through second, so input is stalled while the first six leave, set by
//   the commit sequencer.
//   a new item is taken in the same cycle that the last pending result
//   leaves, so the output register never costs a bubble.
//   when the receiver stalls, the result register holds and in_stall rises
//   until that result is taken.
//   reset: edit and menu closed, flags clear, edit date 20-01-01 weekday 3,
//   times 00:00:00, alarm 00:00; no result pending.
// ----------------------------------------------------------------------------
module clock_set_alarm_controller (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [2:0] kind,
  input  wire  [6:0] rtc_year,
  input  wire  [3:0] rtc_month,
  input  wire  [4:0] rtc_day,
  input  wire  [2:0] rtc_weekday,
  input  wire  [4:0] rtc_hour,
  input  wire  [5:0] rtc_minute,
  input  wire  [5:0] rtc_second,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [2:0] beeps,
  output logic       halt_clock,
  output logic       commit,
  output logic [3:0] field_sel,
  output logic [6:0] field_value,
  output logic [2:0] edit_pos,
  output logic [1:0] alarm_pos,
  output logic       alarm_armed,
  output logic       muted,
  output logic       twelve_hour,
  output logic       last
);
  import csac_pkg::*;

  logic       accept;
  logic       busy;
  rtc_t       rtc;
  fields_t    fields;
  field_cmd_t cmd;
  result_t    res;
  result_t    cur;
  status_t    status;

  assign rtc = '{year: rtc_year, month: rtc_month, day: rtc_day, weekday: rtc_weekday,
                 hour: rtc_hour, minute: rtc_minute, second: rtc_second};

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // mode and flag state, decode of each item
  csac_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (kind),
    .rtc    (rtc),
    .fields (fields),
    .cmd    (cmd),
    .res    (res),
    .status (status)
  );

  // edited fields and alarm time
  csac_fields u_fields (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rtc    (rtc),
    .fields (fields)
  );

  // result register and commit run
  csac_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cur       (cur),
    .cur_last  (last),
    .busy      (busy)
  );

  // state only moves when an item is accepted, i.e. with no result pending or as the
  // last one leaves, so the live state is the state after that item
  assign beeps       = cur.beeps;
  assign commit      = cur.commit;
  assign field_sel   = cur.sel;
  assign field_value = field_read(fields, cur.sel);
  assign halt_clock  = (status.edit_step != EDIT_IDLE);
  assign edit_pos    = status.edit_step;
  assign alarm_pos   = status.menu_step;
  assign alarm_armed = status.armed;
  assign muted       = status.mute;
  assign twelve_hour = status.hour12;

  // commit run walks the fields in order without gaps
  a_commit_walk: assert property (@(posedge clk) disable iff (rst)
    out_valid && commit && !last && !out_stall |=>
      out_valid && commit && (field_sel == $past(field_sel) + 4'd1))
    else $error("commit run skipped a field");

  // commit results go out with the clock running
  a_commit_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && commit |-> !halt_clock && (edit_pos == EDIT_IDLE))
    else $error("commit while editing");

  // no new item while a commit run still has results left
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input taken during commit run");

  // edit and alarm menu never open together
  a_modes: assert property (@(posedge clk) disable iff (rst)
    edit_pos != EDIT_IDLE |-> alarm_pos == MENU_CLOSED)
    else $error("edit and menu both active");

endmodule
`default_nettype wire

@@ rtl/csac_fields.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csac_fields
// edited date/time fields and alarm time, with load and wrap stepping
// ----------------------------------------------------------------------------
module csac_fields (
  input  wire                  clk,
  input  wire                  rst,
  input  csac_pkg::field_cmd_t cmd,
  input  csac_pkg::rtc_t       rtc,
  output csac_pkg::fields_t    fields
);
  import csac_pkg::*;

  fields_t          fields_next;
  logic [VAL_W-1:0] stepped;

  assign stepped = step_value(field_read(fields, cmd.sel), field_lo(cmd.sel),
                              field_hi(cmd.sel), cmd.up);

  always_comb begin
    fields_next = fields;
    if (cmd.load) begin
      fields_next.year    = rtc.year;
      fields_next.month   = rtc.month;
      fields_next.day     = rtc.day;
      fields_next.weekday = rtc.weekday;
      fields_next.hour    = rtc.hour;
      fields_next.minute  = rtc.minute;
      fields_next.second  = rtc.second;
    end else if (cmd.step) begin
      case (cmd.sel)
        SEL_YEAR:         fields_next.year         = stepped;
        SEL_MONTH:        fields_next.month        = stepped[3:0];
        SEL_DAY:          fields_next.day          = stepped[4:0];
        SEL_WEEKDAY:      fields_next.weekday      = stepped[2:0];
        SEL_HOUR:         fields_next.hour         = stepped[4:0];
        SEL_MINUTE:       fields_next.minute       = stepped[5:0];
        SEL_SECOND:       fields_next.second       = stepped[5:0];
        SEL_ALARM_HOUR:   fields_next.alarm_hour   = stepped[4:0];
        SEL_ALARM_MINUTE: fields_next.alarm_minute = stepped[5:0];
        default:          fields_next = fields;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fields.year         <= 7'd20;
      fields.month        <= 4'd1;
      fields.day          <= 5'd1;
      fields.weekday      <= 3'd3;
      fields.hour         <= '0;
      fields.minute       <= '0;
      fields.second       <= '0;
      fields.alarm_hour   <= '0;
      fields.alarm_minute <= '0;
    end else begin
      fields <= fields_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/csac_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csac_ctrl
// key and sample decode: edit step, alarm menu, flags and result record
// ----------------------------------------------------------------------------
module csac_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  wire  [2:0]           kind,
  input  csac_pkg::rtc_t       rtc,
  input  csac_pkg::fields_t    fields,
  output csac_pkg::field_cmd_t cmd,
  output csac_pkg::result_t    res,
  output csac_pkg::status_t    status
);
  import csac_pkg::*;

  status_t     status_next;
  logic        editing;
  logic        menu_open;
  logic        do_commit;
  logic        chime;
  logic        alarm_hit;
  logic [BEEP_W-1:0] beeps;

  assign editing   = (status.edit_step != EDIT_IDLE);
  assign menu_open = (status.menu_step != MENU_CLOSED);
  assign chime     = (rtc.minute == '0) && (rtc.second == '0);
  assign alarm_hit = status.armed && !status.mute && (rtc.hour == fields.alarm_hour) &&
                     (rtc.minute == fields.alarm_minute);

  // next state
  always_comb begin
    status_next = status;
    unique case (kind_t'(kind))
      KIND_SET: begin
        if (!menu_open) begin
          status_next.edit_step = status.edit_step + 3'd1;
        end
      end
      KIND_UP: begin
        if (!editing && !menu_open) begin
          status_next.hour12 = !status.hour12;
        end
      end
      KIND_DOWN: begin
        if (!editing && !menu_open) begin
          status_next.mute = !status.mute;
        end
      end
      KIND_MENU: begin
        if (!editing) begin
          status_next.menu_step = (status.menu_step == MENU_MINUTE) ? MENU_DISARM :
                                  menu_t'(status.menu_step + 2'd1);
          status_next.armed = (status_next.menu_step != MENU_DISARM);
        end
      end
      KIND_MENU_LONG: begin
        if (!editing) begin
          status_next.menu_step = MENU_CLOSED;
        end
      end
      default: status_next = status;
    endcase
  end

  // field command and result record
  always_comb begin
    cmd       = '{load: 1'b0, step: 1'b0, up: 1'b0, sel: SEL_NONE};
    beeps     = BEEP_NONE;
    do_commit = 1'b0;
    unique case (kind_t'(kind))
      KIND_SET: begin
        if (!menu_open) begin
          beeps     = BEEP_ONE;
          cmd.load  = accept && !editing;
          do_commit = (status.edit_step == EDIT_LAST);
        end
      end
      KIND_UP, KIND_DOWN: begin
        cmd.up = (kind_t'(kind) == KIND_UP);
        if (editing) begin
          beeps    = BEEP_ONE;
          cmd.step = accept;
          cmd.sel  = sel_t'({1'b0, status.edit_step});
        end else if (menu_open) begin
          beeps    = BEEP_ONE;
          cmd.step = accept && (status.menu_step != MENU_DISARM);
          cmd.sel  = (status.menu_step == MENU_HOUR) ? SEL_ALARM_HOUR : SEL_ALARM_MINUTE;
        end else if (kind_t'(kind) == KIND_UP) begin
          beeps = BEEP_ONE;
        end
      end
      KIND_MENU: begin
        if (!editing) begin
          beeps = BEEP_ONE;
        end
      end
      KIND_SAMPLE: begin
        if (!editing && !menu_open) begin
          beeps = (chime ? BEEP_CHIME : BEEP_NONE) + (alarm_hit ? BEEP_ONE : BEEP_NONE);
        end
      end
      default: beeps = BEEP_NONE;
    endcase

    res.beeps  = beeps;
    res.commit = do_commit;
    if (do_commit) begin
      res.sel = SEL_YEAR;
    end else if (status_next.edit_step != EDIT_IDLE) begin
      res.sel = sel_t'({1'b0, status_next.edit_step});
    end else if (status_next.menu_step == MENU_HOUR) begin
      res.sel = SEL_ALARM_HOUR;
    end else if (status_next.menu_step == MENU_MINUTE) begin
      res.sel = SEL_ALARM_MINUTE;
    end else begin
      res.sel = SEL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '{edit_step: EDIT_IDLE, menu_step: MENU_CLOSED,
                  armed: 1'b0, mute: 1'b0, hour12: 1'b0};
    end else if (accept) begin
      status <= status_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/csac_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csac_out
// result register and commit sequencer, one result per drained cycle
// ----------------------------------------------------------------------------
module csac_out (
  input  wire               clk,
  input  wire               rst,
  input  wire               load,
  input  csac_pkg::result_t res,
  input  wire               out_stall,
  output logic              out_valid,
  output csac_pkg::result_t cur,
  output logic              cur_last,
  output logic              busy
);
  import csac_pkg::*;

  logic drain;

  assign cur_last = !cur.commit || (cur.sel == SEL_SECOND);
  assign drain    = out_valid && !out_stall;
  // hold off new items unless the register is empty or frees up this cycle
  assign busy     = out_valid && !(drain && cur_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!busy) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && !cur_last) begin
      cur.sel   <= sel_t'(cur.sel + 4'd1);
      cur.beeps <= BEEP_NONE;
    end else if (!busy && load) begin
      cur <= res;
    end
  end

endmodule
`default_nettype wire
